### hw/rtl/atsm_pkg.sv
// Package with the shared constants of the affine texture span mapper.
package atsm_pkg;
  localparam int unsigned TexSizeLog2Max = 8;
  localparam int unsigned MaxSpan = 768;
  localparam int unsigned FracBits = 14;
  localparam int unsigned Group = 12;
  localparam int unsigned StoreDepth = 65536;
  localparam int unsigned StoreAw = 16;
  localparam int unsigned TexelW = 16;

  localparam logic [1:0] RegTransparent = 2'd0;
  localparam logic [1:0] RegKeyColor = 2'd1;
  localparam logic [1:0] RegTexSize = 2'd2;

  localparam logic FuncTexel = 1'b0;
  localparam logic FuncSpan = 1'b1;
endpackage

### hw/rtl/affine_texture_span_mapper.sv
// Top level of the affine texture span mapper: texel store, divider, span walker and output.
//
// A texel write request passes through the accept state and then the store write. An
// empty span is accepted and gives no result. A span request passes through the accept
// state, a radix-2 divider that runs the u and v step divisions side by side, one quotient
// bit per cycle, and a sign fix state before its first pixel read. Each group of up to 12
// pixels then issues one read per pixel on the single texture store read port, waits in a
// collect state for the last read to land and then loads the output register. The pixel
// count is capped at MAX_SPAN. Results wait in an output register; a group is not loaded
// while it is full and not being taken. The texture store holds no reset value and must be
// written before it is read.
module affine_texture_span_mapper
  import atsm_pkg::*;
#(
  parameter int unsigned MAX_SPAN = atsm_pkg::MaxSpan
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [15:0] texel_index_i,
  input  logic [15:0] texel_value_i,
  input  logic [11:0] row_i,
  input  logic signed [31:0] left_x_i,
  input  logic signed [31:0] right_x_i,
  input  logic signed [31:0] left_u_i,
  input  logic signed [31:0] left_v_i,
  input  logic signed [31:0] right_u_i,
  input  logic signed [31:0] right_v_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [11:0] out_row_o,
  output logic signed [17:0] start_x_o,
  output logic [63:0] pixels_low_o,
  output logic [63:0] pixels_mid_o,
  output logic [63:0] pixels_high_o,
  output logic [11:0] write_mask_o,
  output logic        last_o
);
  localparam int unsigned CntW = $clog2(MAX_SPAN + 1);
  localparam int unsigned SlotW = $clog2(Group);

  typedef enum logic [2:0] {
    StIdle, StTexel, StDiv, StFix, StWalk, StCollect, StEmit
  } state_e;

  state_e state_q;
  logic        tmode_q;
  logic [15:0] key_q;
  logic [3:0]  lgreg_q;

  // Configuration port.
  logic cfg_we;
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmode_q <= 1'b0;
      key_q <= '0;
      lgreg_q <= 4'd8;
    end else if (cfg_we) begin
      case (paddr[3:2])
        RegTransparent: tmode_q <= pwdata[0];
        RegKeyColor:    key_q <= pwdata[15:0];
        RegTexSize:     lgreg_q <= pwdata[3:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (paddr[3:2])
      RegTransparent: prdata = {31'd0, tmode_q};
      RegKeyColor:    prdata = {16'd0, key_q};
      RegTexSize:     prdata = {28'd0, lgreg_q};
      default:        prdata = '0;
    endcase
  end

  // Span registers.
  logic [11:0] row_q;
  logic signed [18:0] rx_q;
  logic [31:0] width_q;
  logic [CntW-1:0] count_q, issued_q, recv_q;
  logic [31:0] u_q, v_q, ustep_q, vstep_q, mask_q;
  logic [3:0] lg_q;
  logic [15:0] tidx_q, tval_q;

  // Divider: two magnitudes divided by width in parallel.
  logic [31:0] nu_q, nv_q, ru_q, rv_q;
  logic neg_u_q, neg_v_q;
  logic [5:0] dcnt_q;
  logic [32:0] ru_try, rv_try;
  assign ru_try = {ru_q, nu_q[31]} - {1'b0, width_q};
  assign rv_try = {rv_q, nv_q[31]} - {1'b0, width_q};

  // Pixel group.
  logic [TexelW*Group-1:0] pix_q;
  logic [Group-1:0] wm_q;
  logic [SlotW-1:0] slot_q, rslot_q;
  logic rvalid_q;
  logic [CntW-1:0] gbase_q;

  logic out_full_q;
  logic emit_go;
  logic [TexelW-1:0] rdata;
  logic ram_we;
  logic [StoreAw-1:0] ram_addr;

  // Input arithmetic.
  logic signed [18:0] rx_in, lx_in;
  logic signed [19:0] w_in;
  logic [31:0] du_in, dv_in;
  assign rx_in = 19'(right_x_i >>> FracBits);
  assign lx_in = 19'(left_x_i >>> FracBits);
  assign w_in = 20'(lx_in) - 20'(rx_in);
  assign du_in = left_u_i - right_u_i;
  assign dv_in = left_v_i - right_v_i;

  logic [31:0] idx_full;
  assign idx_full = ((v_q & mask_q) | u_q) >> FracBits;

  assign ram_we = (state_q == StTexel);
  assign ram_addr = ram_we ? tidx_q : idx_full[StoreAw-1:0];
  assign in_ready_o = (state_q == StIdle);
  assign emit_go = (state_q == StEmit) && (!out_full_q || out_ready_i);

  atsm_ram #(.Width(TexelW), .Depth(StoreDepth)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (tval_q),
    .rdata_o (rdata)
  );

  logic [3:0] lg_sat;
  assign lg_sat = (lgreg_q > 4'(TexSizeLog2Max)) ? 4'(TexSizeLog2Max) : lgreg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      out_full_q <= 1'b0;
      rvalid_q <= 1'b0;
      issued_q <= '0;
      recv_q <= '0;
    end else begin
      out_full_q <= emit_go || (out_full_q && !out_ready_i);
      rvalid_q <= (state_q == StWalk);
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            if (func_i == FuncTexel) begin
              tidx_q <= texel_index_i;
              tval_q <= texel_value_i;
              state_q <= StTexel;
            end else if (w_in > 0) begin
              row_q <= row_i;
              rx_q <= rx_in;
              width_q <= 32'(w_in);
              count_q <= (w_in > 20'(MAX_SPAN)) ? CntW'(MAX_SPAN) : CntW'(w_in);
              lg_q <= lg_sat;
              mask_q <= ((32'd1 << lg_sat) - 32'd1) << (FracBits + 32'(lg_sat));
              u_q <= right_u_i;
              v_q <= right_v_i << lg_sat;
              neg_u_q <= du_in[31];
              neg_v_q <= dv_in[31];
              nu_q <= du_in[31] ? -du_in : du_in;
              nv_q <= dv_in[31] ? -dv_in : dv_in;
              ru_q <= '0;
              rv_q <= '0;
              dcnt_q <= '0;
              state_q <= StDiv;
            end
          end
        end
        StTexel: state_q <= StIdle;
        StDiv: begin
          if (!ru_try[32]) begin
            ru_q <= ru_try[31:0];
            nu_q <= {nu_q[30:0], 1'b1};
          end else begin
            ru_q <= {ru_q[30:0], nu_q[31]};
            nu_q <= {nu_q[30:0], 1'b0};
          end
          if (!rv_try[32]) begin
            rv_q <= rv_try[31:0];
            nv_q <= {nv_q[30:0], 1'b1};
          end else begin
            rv_q <= {rv_q[30:0], nv_q[31]};
            nv_q <= {nv_q[30:0], 1'b0};
          end
          dcnt_q <= dcnt_q + 6'd1;
          if (dcnt_q == 6'd31) state_q <= StFix;
        end
        StFix: begin
          ustep_q <= neg_u_q ? -nu_q : nu_q;
          vstep_q <= (neg_v_q ? -nv_q : nv_q) << lg_q;
          issued_q <= '0;
          recv_q <= '0;
          gbase_q <= '0;
          slot_q <= '0;
          pix_q <= '0;
          wm_q <= '0;
          state_q <= StWalk;
        end
        StWalk: begin
          // One texel read per cycle at the current u, v.
          rslot_q <= slot_q;
          u_q <= u_q + ustep_q;
          v_q <= v_q + vstep_q;
          issued_q <= issued_q + CntW'(1);
          slot_q <= slot_q + SlotW'(1);
          if ((32'(issued_q) + 32'd1 == 32'(count_q)) || (slot_q == SlotW'(Group - 1))) begin
            state_q <= StCollect;
          end
        end
        StCollect: begin
          if (!rvalid_q) state_q <= StEmit;
        end
        StEmit: begin
          if (emit_go) begin
            out_row_o <= row_q;
            start_x_o <= 18'(rx_q + 19'(gbase_q));
            pixels_low_o <= pix_q[63:0];
            pixels_mid_o <= pix_q[127:64];
            pixels_high_o <= pix_q[191:128];
            write_mask_o <= wm_q;
            last_o <= (issued_q == count_q);
            pix_q <= '0;
            wm_q <= '0;
            slot_q <= '0;
            gbase_q <= issued_q;
            state_q <= (issued_q == count_q) ? StIdle : StWalk;
          end
        end
        default: state_q <= StIdle;
      endcase
      if (rvalid_q && !(tmode_q && rdata == key_q)) begin
        pix_q[rslot_q*TexelW +: TexelW] <= rdata;
        wm_q[rslot_q] <= 1'b1;
      end
      if (rvalid_q) recv_q <= recv_q + CntW'(1);
    end
  end

  assign out_valid_o = out_full_q;

  ap_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !rvalid_q) else $error("read in flight while idle");
  ap_recv_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    recv_q <= issued_q) else $error("more reads returned than issued");
  ap_emit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o) else $error("result dropped");
endmodule

### hw/rtl/atsm_ram.sv
// Generic single-port synchronous RAM with a registered read.
module atsm_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
